>>> design/icrgb_pkg.sv
`timescale 1ns / 1ps

package icrgb_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned MAX_COUNT_RESET = 1000;

  localparam int unsigned SCALE_GREEN = 255;
  localparam int unsigned SCALE_WAVE  = 300 * 256;
  localparam int unsigned WL_BASE     = 400 * 256;

  localparam int unsigned QUO_BITS = $clog2(SCALE_WAVE);

  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAX_COUNT,
    REG_THEME
  } cfg_reg_e;

  typedef enum logic {
    THEME_GREEN,
    THEME_SPECTRAL
  } theme_e;

endpackage

>>> design/icrgb_front.sv
`timescale 1ns / 1ps

module icrgb_front #(
  parameter int unsigned COUNT_BITS = icrgb_pkg::COUNT_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_valid_i,
  input  logic [icrgb_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [COUNT_BITS-1:0]                     cfg_data_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic [COUNT_BITS-1:0]                     count_i,
  output logic                                      push_valid_o,
  input  logic                                      push_ready_i,
  output logic [COUNT_BITS+icrgb_pkg::QUO_BITS-1:0] dividend_o,
  output logic [COUNT_BITS-1:0]                     divisor_o,
  output icrgb_pkg::theme_e                         theme_o
);
  import icrgb_pkg::*;

  localparam int unsigned NUM_BITS = COUNT_BITS + QUO_BITS;

  logic [COUNT_BITS-1:0] max_q;
  theme_e                theme_q;

  logic                  load;
  logic [COUNT_BITS-1:0] clamp;
  logic [NUM_BITS-1:0]   dividend;
  logic [COUNT_BITS-1:0] divisor;

  logic                  fr_valid_q, fr_valid_d;
  logic [NUM_BITS-1:0]   fr_dividend_q;
  logic [COUNT_BITS-1:0] fr_divisor_q;
  theme_e                fr_theme_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= COUNT_BITS'(MAX_COUNT_RESET);
      theme_q <= THEME_GREEN;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MAX_COUNT: max_q <= cfg_data_i;
        REG_THEME:     theme_q <= theme_e'(cfg_data_i[0]);
      endcase
    end
  end

  // A count at or above the limit renders as zero. With a zero limit the
  // dividend is always zero, so a divisor of one gives the bottom of the range.
  always_comb begin
    clamp = (count_i >= max_q) ? '0 : count_i;
    if (theme_q == THEME_SPECTRAL) begin
      dividend = NUM_BITS'(clamp) * NUM_BITS'(SCALE_WAVE);
    end else begin
      dividend = NUM_BITS'(clamp) * NUM_BITS'(SCALE_GREEN);
    end
    divisor = (max_q == '0) ? COUNT_BITS'(1) : max_q;
  end

  assign in_stall_o = fr_valid_q && !push_ready_i;
  assign load       = in_valid_i && !in_stall_o;
  assign fr_valid_d = load || (fr_valid_q && !push_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fr_dividend_q <= dividend;
      fr_divisor_q  <= divisor;
      fr_theme_q    <= theme_q;
    end
  end

  assign push_valid_o = fr_valid_q;
  assign dividend_o   = fr_dividend_q;
  assign divisor_o    = fr_divisor_q;
  assign theme_o      = fr_theme_q;

endmodule

>>> design/icrgb_fifo.sv
`timescale 1ns / 1ps

module icrgb_fifo #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  logic [DATA_BITS-1:0] push_data_i,
  input  logic                 pop_i,
  output logic                 pop_valid_o,
  output logic [DATA_BITS-1:0] pop_data_o
);
  import icrgb_pkg::*;

  localparam int unsigned PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS = PTR_BITS + 1;

  logic [DATA_BITS-1:0] mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0]  count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != CNT_BITS'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign count_d      = count_q + CNT_BITS'(push) - CNT_BITS'(pop);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(FIFO_DEPTH))
    else $error("queue fill count exceeds depth");

  a_ptr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    PTR_BITS'(wr_ptr_q - rd_ptr_q) == count_q[PTR_BITS-1:0])
    else $error("queue pointers disagree with fill count");
`endif

endmodule

>>> design/icrgb_div.sv
`timescale 1ns / 1ps

module icrgb_div #(
  parameter int unsigned COUNT_BITS = icrgb_pkg::COUNT_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      adv_i,
  input  logic                                      in_valid_i,
  input  logic [COUNT_BITS+icrgb_pkg::QUO_BITS-1:0] dividend_i,
  input  logic [COUNT_BITS-1:0]                     divisor_i,
  input  icrgb_pkg::theme_e                         theme_i,
  output logic                                      valid_o,
  output logic [icrgb_pkg::QUO_BITS-1:0]            quo_o,
  output icrgb_pkg::theme_e                         theme_o
);
  import icrgb_pkg::*;

  localparam int unsigned NUM_BITS = COUNT_BITS + QUO_BITS;

  logic [QUO_BITS-1:0]   v_q, v_d;
  logic [COUNT_BITS-1:0] r_q  [QUO_BITS];
  logic [COUNT_BITS-1:0] r_d  [QUO_BITS];
  logic [QUO_BITS-1:0]   lq_q [QUO_BITS];
  logic [QUO_BITS-1:0]   lq_d [QUO_BITS];
  logic [COUNT_BITS-1:0] d_q  [QUO_BITS];
  logic [COUNT_BITS-1:0] d_d  [QUO_BITS];
  theme_e                th_q [QUO_BITS];
  theme_e                th_d [QUO_BITS];

  logic [COUNT_BITS-1:0] src_r, src_d;
  logic [QUO_BITS-1:0]   src_lq;
  theme_e                src_th;
  logic [COUNT_BITS:0]   trial, rem;
  logic                  ge;

  // One restoring step per stage. The remainder starts below the divisor
  // because the scaled count never reaches the divisor times two to the
  // quotient width, so every step yields one quotient bit.
  always_comb begin
    src_r  = '0;
    src_d  = '0;
    src_lq = '0;
    src_th = THEME_GREEN;
    trial  = '0;
    rem    = '0;
    ge     = 1'b0;
    for (int j = 0; j < int'(QUO_BITS); j++) begin
      if (j == 0) begin
        src_r    = dividend_i[NUM_BITS-1:QUO_BITS];
        src_lq   = dividend_i[QUO_BITS-1:0];
        src_d    = divisor_i;
        src_th   = theme_i;
        v_d[j]   = in_valid_i;
      end else begin
        src_r    = r_q[j-1];
        src_lq   = lq_q[j-1];
        src_d    = d_q[j-1];
        src_th   = th_q[j-1];
        v_d[j]   = v_q[j-1];
      end
      trial    = {src_r, src_lq[QUO_BITS-1]};
      ge       = (trial >= {1'b0, src_d});
      rem      = ge ? (trial - {1'b0, src_d}) : trial;
      r_d[j]   = rem[COUNT_BITS-1:0];
      lq_d[j]  = {src_lq[QUO_BITS-2:0], ge};
      d_d[j]   = src_d;
      th_d[j]  = src_th;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q  <= r_d;
      lq_q <= lq_d;
      d_q  <= d_d;
      th_q <= th_d;
    end
  end

  assign valid_o = v_q[QUO_BITS-1];
  assign quo_o   = lq_q[QUO_BITS-1];
  assign theme_o = th_q[QUO_BITS-1];

`ifndef NO_ASSERTIONS
  a_rem_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (r_q[QUO_BITS-1] < d_q[QUO_BITS-1]))
    else $error("divider remainder not below divisor");

  a_green_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (theme_o == THEME_GREEN)) |-> (quo_o < QUO_BITS'(SCALE_GREEN)))
    else $error("green scale quotient out of range");
`endif

endmodule

>>> design/icrgb_color.sv
`timescale 1ns / 1ps

module icrgb_color (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [icrgb_pkg::QUO_BITS-1:0] quo_i,
  input  icrgb_pkg::theme_e              theme_i,
  output logic                           adv_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o
);
  import icrgb_pkg::*;

  localparam int unsigned WL_BITS     = 18;
  localparam int unsigned NM_BITS     = 10;
  localparam int unsigned D_BITS      = 15;
  localparam int unsigned X_BITS      = D_BITS + 8;
  localparam int unsigned W_BITS      = 7;
  localparam int unsigned RECIP_BITS  = 29;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned P_BITS      = X_BITS + RECIP_BITS;
  localparam int unsigned T_BITS      = 16;
  localparam int unsigned K0_BITS     = 16;
  localparam int unsigned C1_BITS     = 18;
  localparam int unsigned C2_BITS     = 17;
  localparam int unsigned SUM_BITS    = 20;
  localparam int unsigned NUM_BANDS   = 11;

  localparam int unsigned RED_MUL     = 93;
  localparam int unsigned RED_RECIP   = 41944;
  localparam int unsigned RED_SHIFT   = 22;
  localparam int unsigned BLUE_MUL    = 3;
  localparam int unsigned BLUE_RECIP  = 6554;
  localparam int unsigned BLUE_SHIFT  = 16;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_NONE  = 2'd3;

  typedef enum logic [3:0] {
    BAND_NONE,
    BAND_R400,
    BAND_R410,
    BAND_R545,
    BAND_R595,
    BAND_R650,
    BAND_G415,
    BAND_G475,
    BAND_G585,
    BAND_B400,
    BAND_B475
  } band_e;

  // Each band evaluates k0 +/- c1*t +/- c2*t^2 with t the position in the band.
  typedef struct packed {
    logic [1:0]            ch;
    logic [NM_BITS-1:0]    lo;
    logic [NM_BITS-1:0]    hi;
    logic [W_BITS-1:0]     w;
    logic [RECIP_BITS-1:0] recip;
    logic [K0_BITS-1:0]    k0;
    logic [C1_BITS-1:0]    c1;
    logic                  neg1;
    logic [C2_BITS-1:0]    c2;
    logic                  neg2;
  } band_t;

  function automatic band_t band_info(band_e sel);
    band_t b;
    unique case (sel)
      BAND_R400: b = '{CH_RED, 10'd400, 10'd410, 7'd10, 29'd429496729,
                       16'd0, 18'd21627, 1'b0, 17'd13107, 1'b1};
      BAND_R410: b = '{CH_RED, 10'd410, 10'd475, 7'd65, 29'd66076419,
                       16'd9175, 18'd0, 1'b0, 17'd8520, 1'b1};
      BAND_R545: b = '{CH_RED, 10'd545, 10'd595, 7'd50, 29'd85899345,
                       16'd0, 18'd129761, 1'b0, 17'd65536, 1'b1};
      BAND_R595: b = '{CH_RED, 10'd595, 10'd650, 7'd55, 29'd78090314,
                       16'd64225, 18'd3932, 1'b0, 17'd26214, 1'b1};
      BAND_R650: b = '{CH_RED, 10'd650, 10'd700, 7'd50, 29'd85899345,
                       16'd42598, 18'd55050, 1'b1, 17'd13107, 1'b0};
      BAND_G415: b = '{CH_GREEN, 10'd415, 10'd475, 7'd60, 29'd71582788,
                       16'd0, 18'd0, 1'b0, 17'd52429, 1'b0};
      BAND_G475: b = '{CH_GREEN, 10'd475, 10'd590, 7'd115, 29'd37347541,
                       16'd52429, 18'd49807, 1'b0, 17'd52429, 1'b1};
      BAND_G585: b = '{CH_GREEN, 10'd585, 10'd639, 7'd54, 29'd79536431,
                       16'd55050, 18'd55050, 1'b1, 17'd0, 1'b0};
      BAND_B400: b = '{CH_BLUE, 10'd400, 10'd475, 7'd75, 29'd57266230,
                       16'd0, 18'd144179, 1'b0, 17'd98304, 1'b1};
      BAND_B475: b = '{CH_BLUE, 10'd475, 10'd560, 7'd85, 29'd50529027,
                       16'd45875, 18'd65536, 1'b1, 17'd19661, 1'b0};
      default:   b = '{CH_NONE, 10'd0, 10'd0, 7'd1, 29'd0,
                       16'd0, 18'd0, 1'b0, 17'd0, 1'b0};
    endcase
    return b;
  endfunction

  // The earliest band of the channel that holds the wavelength wins.
  function automatic band_e pick_band(logic [WL_BITS-1:0] wl, logic [1:0] ch);
    band_t b;
    band_e sel;
    sel = BAND_NONE;
    for (int i = NUM_BANDS - 1; i >= 1; i--) begin
      b = band_info(band_e'(i));
      if (b.ch == ch && wl >= {b.lo, 8'b0} && wl < {b.hi, 8'b0}) begin
        sel = band_e'(i);
      end
    end
    return sel;
  endfunction

  function automatic logic [7:0] to_byte(logic signed [SUM_BITS-1:0] s);
    logic [SUM_BITS+7:0] prod;
    logic [11:0]         v;
    prod = (SUM_BITS+8)'(s[SUM_BITS-2:0]) * (SUM_BITS+8)'(255);
    v    = prod[SUM_BITS+7:16];
    if (s < 0) begin
      return 8'd0;
    end else if (v > 12'd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

  logic                 adv;
  logic [WL_BITS-1:0]   wl;
  logic [7:0]           gray_v;
  logic [14:0]          gray_rx;
  logic [30:0]          gray_rp;
  logic [9:0]           gray_bx;
  logic [23:0]          gray_bp;
  logic [7:0]           gray [3];

  band_t                bi0, bi1, bi2, bi3, bi4;
  band_e                c0_band [3];
  logic [D_BITS-1:0]    c0_d    [3];
  logic [P_BITS-1:0]    c1_p;
  logic [T_BITS-1:0]    c1_q0   [3];
  logic [X_BITS-1:0]    c2_x, c2_qw, c2_rem;
  logic [T_BITS-1:0]    c2_t    [3];
  logic [2*T_BITS-1:0]  c3_tt;
  logic [C1_BITS+T_BITS-1:0] c3_p1;
  logic [T_BITS-1:0]    c3_t2   [3];
  logic [C1_BITS-1:0]   c3_a1   [3];
  logic [C2_BITS+T_BITS-1:0] c4_p2;
  logic [C2_BITS-1:0]   c4_a2   [3];
  logic signed [SUM_BITS-1:0] e0, e1, e2;
  logic signed [SUM_BITS-1:0] c5_sum [3];
  logic [7:0]           spec    [3];

  logic [5:0]           v_q;
  theme_e               th_q    [6];
  logic [7:0]           gray_q  [6][3];
  band_e                band_q  [5][3];
  logic [D_BITS-1:0]    s0_d_q  [3];
  logic [D_BITS-1:0]    s1_d_q  [3];
  logic [T_BITS-1:0]    s1_q0_q [3];
  logic [T_BITS-1:0]    s2_t_q  [3];
  logic [T_BITS-1:0]    s3_t2_q [3];
  logic [C1_BITS-1:0]   s3_a1_q [3];
  logic [C1_BITS-1:0]   s4_a1_q [3];
  logic [C2_BITS-1:0]   s4_a2_q [3];
  logic signed [SUM_BITS-1:0] s5_sum_q [3];

  logic                 out_valid_q;
  logic [7:0]           out_q   [3];

  assign adv   = !out_valid_q || !out_stall_i;
  assign adv_o = adv;

  // Green theme: red is 93/100 and blue 3/10 of the scaled value, each by a
  // reciprocal that is exact over the eight bit range.
  always_comb begin
    gray_v  = quo_i[7:0];
    gray_rx = 15'(gray_v) * 15'(RED_MUL);
    gray_rp = 31'(gray_rx) * 31'(RED_RECIP);
    gray_bx = 10'(gray_v) * 10'(BLUE_MUL);
    gray_bp = 24'(gray_bx) * 24'(BLUE_RECIP);
    gray[0] = gray_rp[RED_SHIFT +: 8];
    gray[1] = gray_v;
    gray[2] = gray_bp[BLUE_SHIFT +: 8];
  end

  assign wl = WL_BITS'(WL_BASE) + WL_BITS'(quo_i);

  always_comb begin
    bi0    = '0;
    bi1    = '0;
    bi2    = '0;
    bi3    = '0;
    bi4    = '0;
    c1_p   = '0;
    c2_x   = '0;
    c2_qw  = '0;
    c2_rem = '0;
    c3_tt  = '0;
    c3_p1  = '0;
    c4_p2  = '0;
    e0     = '0;
    e1     = '0;
    e2     = '0;
    for (int l = 0; l < 3; l++) begin
      c0_band[l] = pick_band(wl, 2'(l));
      bi0        = band_info(c0_band[l]);
      c0_d[l]    = D_BITS'(wl - {bi0.lo, 8'b0});

      // Band position: (d * 256) / w by reciprocal, then one correction.
      bi1        = band_info(band_q[0][l]);
      c1_p       = P_BITS'({s0_d_q[l], 8'b0}) * P_BITS'(bi1.recip);
      c1_q0[l]   = c1_p[RECIP_SHIFT +: T_BITS];

      bi2        = band_info(band_q[1][l]);
      c2_x       = {s1_d_q[l], 8'b0};
      c2_qw      = X_BITS'(s1_q0_q[l]) * X_BITS'(bi2.w);
      c2_rem     = c2_x - c2_qw;
      c2_t[l]    = s1_q0_q[l] + T_BITS'(c2_rem >= X_BITS'(bi2.w));

      bi3        = band_info(band_q[2][l]);
      c3_tt      = (2*T_BITS)'(s2_t_q[l]) * (2*T_BITS)'(s2_t_q[l]);
      c3_t2[l]   = c3_tt[2*T_BITS-1:T_BITS];
      c3_p1      = (C1_BITS+T_BITS)'(bi3.c1) * (C1_BITS+T_BITS)'(s2_t_q[l]);
      c3_a1[l]   = c3_p1[C1_BITS+T_BITS-1:T_BITS];

      bi4        = band_info(band_q[3][l]);
      c4_p2      = (C2_BITS+T_BITS)'(bi4.c2) * (C2_BITS+T_BITS)'(s3_t2_q[l]);
      c4_a2[l]   = c4_p2[C2_BITS+T_BITS-1:T_BITS];

      bi0        = band_info(band_q[4][l]);
      e0         = SUM_BITS'(bi0.k0);
      e1         = SUM_BITS'(s4_a1_q[l]);
      e2         = SUM_BITS'(s4_a2_q[l]);
      c5_sum[l]  = e0 + (bi0.neg1 ? -e1 : e1) + (bi0.neg2 ? -e2 : e2);

      spec[l]    = to_byte(s5_sum_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[4:0], in_valid_i};
      out_valid_q <= v_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      th_q[0]   <= theme_i;
      gray_q[0] <= gray;
      band_q[0] <= c0_band;
      s0_d_q    <= c0_d;
      for (int s = 1; s < 6; s++) begin
        th_q[s]   <= th_q[s-1];
        gray_q[s] <= gray_q[s-1];
      end
      for (int s = 1; s < 5; s++) begin
        band_q[s] <= band_q[s-1];
      end
      s1_d_q   <= s0_d_q;
      s1_q0_q  <= c1_q0;
      s2_t_q   <= c2_t;
      s3_t2_q  <= c3_t2;
      s3_a1_q  <= c3_a1;
      s4_a1_q  <= s3_a1_q;
      s4_a2_q  <= c4_a2;
      s5_sum_q <= c5_sum;
      for (int k = 0; k < 3; k++) begin
        out_q[k] <= (th_q[5] == THEME_GREEN) ? gray_q[5][k] : spec[k];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_q[0];
  assign green_o     = out_q[1];
  assign blue_o      = out_q[2];

`ifndef NO_ASSERTIONS
  a_green_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[5] && (th_q[5] == THEME_GREEN)) |->
      (gray_q[5][2] <= gray_q[5][0]) && (gray_q[5][0] <= gray_q[5][1]))
    else $error("green theme channels out of order");
`endif

endmodule

>>> design/iteration_count_to_rgb_palette.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake                   Payload
// in       in   in_valid_i / in_stall_o     count_i
// out      out  out_valid_o / out_stall_i   red_o, green_o, blue_o
// cfg      in   cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One transaction per cycle is taken on the input and delivered on the output while
// neither side stalls. A transaction passes the front register, the queue, one
// divider stage per quotient bit (17), six color stages and the output register.
// Reset clears all valid state and loads max_count 1000 and theme 0.
// An output stall while out_valid_o is high freezes the divider and color pipeline; the four-entry queue
// keeps the input side taking transactions until it fills.
module iteration_count_to_rgb_palette #(
  parameter int unsigned COUNT_BITS = icrgb_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [icrgb_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COUNT_BITS-1:0]              cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [COUNT_BITS-1:0]              count_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         red_o,
  output logic [7:0]                         green_o,
  output logic [7:0]                         blue_o
);
  import icrgb_pkg::*;

  localparam int unsigned NUM_BITS  = COUNT_BITS + QUO_BITS;
  localparam int unsigned DATA_BITS = NUM_BITS + COUNT_BITS + 1;

  logic                  push_valid, push_ready;
  logic [NUM_BITS-1:0]   fr_dividend;
  logic [COUNT_BITS-1:0] fr_divisor;
  theme_e                fr_theme;

  logic                  adv;
  logic                  q_valid;
  logic [DATA_BITS-1:0]  q_data;

  logic                  div_valid;
  logic [QUO_BITS-1:0]   div_quo;
  theme_e                div_theme;

  assign cfg_ready_o = 1'b1;

  icrgb_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .count_i      (count_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .dividend_o   (fr_dividend),
    .divisor_o    (fr_divisor),
    .theme_o      (fr_theme)
  );

  icrgb_fifo #(
    .DATA_BITS(DATA_BITS)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({fr_theme, fr_divisor, fr_dividend}),
    .pop_i        (adv),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_data)
  );

  icrgb_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (q_valid),
    .dividend_i (q_data[NUM_BITS-1:0]),
    .divisor_i  (q_data[NUM_BITS+COUNT_BITS-1:NUM_BITS]),
    .theme_i    (theme_e'(q_data[DATA_BITS-1])),
    .valid_o    (div_valid),
    .quo_o      (div_quo),
    .theme_o    (div_theme)
  );

  icrgb_color u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .quo_i       (div_quo),
    .theme_i     (div_theme),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

>>> tb/tb_iteration_count_to_rgb_palette.sv
`timescale 1ns / 1ps

module tb_iteration_count_to_rgb_palette;
  import icrgb_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_reg_e    cfg_index_i = REG_MAX_COUNT;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] count_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;

  logic [15:0] limit_reg = 16'(MAX_COUNT_RESET);
  theme_e      palette_reg = THEME_GREEN;

  logic [15:0] pending_counts[$];
  pixel_t      expected_pixels[$];
  logic        in_taken = 1'b0;
  logic        steady = 1'b0;
  int          mismatches = 0;

  iteration_count_to_rgb_palette u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .count_i     (count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic bit in_band(longint wl, longint lo, longint hi);
    return wl >= lo * 256 && wl < hi * 256;
  endfunction

  function automatic longint band_frac(longint wl, longint lo, longint hi);
    return ((wl - lo * 256) <<< 16) / ((hi - lo) * 256);
  endfunction

  function automatic logic [7:0] to_level(longint s);
    longint v;
    if (s < 0) return 8'd0;
    v = (s * 255) >>> 16;
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic pixel_t spectrum_color(longint wl);
    longint r, g, b, t, t2;
    pixel_t px;
    r = 0;
    g = 0;
    b = 0;
    if (in_band(wl, 400, 410)) begin
      t = band_frac(wl, 400, 410);
      t2 = qmul(t, t);
      r = qmul(21627, t) - qmul(13107, t2);
    end else if (in_band(wl, 410, 475)) begin
      t = band_frac(wl, 410, 475);
      t2 = qmul(t, t);
      r = 9175 - qmul(8520, t2);
    end else if (in_band(wl, 545, 595)) begin
      t = band_frac(wl, 545, 595);
      t2 = qmul(t, t);
      r = qmul(129761, t) - t2;
    end else if (in_band(wl, 595, 650)) begin
      t = band_frac(wl, 595, 650);
      t2 = qmul(t, t);
      r = 64225 + qmul(3932, t) - qmul(26214, t2);
    end else if (in_band(wl, 650, 700)) begin
      t = band_frac(wl, 650, 700);
      t2 = qmul(t, t);
      r = 42598 - qmul(55050, t) + qmul(13107, t2);
    end
    if (in_band(wl, 415, 475)) begin
      t = band_frac(wl, 415, 475);
      t2 = qmul(t, t);
      g = qmul(52429, t2);
    end else if (in_band(wl, 475, 590)) begin
      t = band_frac(wl, 475, 590);
      t2 = qmul(t, t);
      g = 52429 + qmul(49807, t) - qmul(52429, t2);
    end else if (in_band(wl, 585, 639)) begin
      t = band_frac(wl, 585, 639);
      g = 55050 - qmul(55050, t);
    end
    if (in_band(wl, 400, 475)) begin
      t = band_frac(wl, 400, 475);
      t2 = qmul(t, t);
      b = qmul(144179, t) - qmul(98304, t2);
    end else if (in_band(wl, 475, 560)) begin
      t = band_frac(wl, 475, 560);
      t2 = qmul(t, t);
      b = 45875 - t + qmul(19661, t2);
    end
    px.red = to_level(r);
    px.green = to_level(g);
    px.blue = to_level(b);
    return px;
  endfunction

  function automatic pixel_t palette_color(logic [15:0] raw);
    longint c, lim, v, wl;
    pixel_t px;
    c = raw;
    lim = limit_reg;
    if (c >= lim) c = 0;
    if (palette_reg == THEME_GREEN) begin
      v = (lim != 0) ? c * 255 / lim : 0;
      px.red = 8'(v * 93 / 100);
      px.green = 8'(v);
      px.blue = 8'(v * 3 / 10);
    end else begin
      wl = 102400 + ((lim != 0) ? c * 76800 / lim : 0);
      px = spectrum_color(wl);
    end
    return px;
  endfunction

  function automatic logic [15:0] pick_count(logic [15:0] lim);
    int sel;
    sel = $urandom_range(99);
    if (lim != 0 && sel < 80) return 16'($urandom_range(lim - 1, 0));
    if (sel < 90) return 16'($urandom_range(65535, lim));
    return 16'($urandom());
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= !steady && ($urandom_range(99) < 12);
      if (!in_valid_i || in_taken) begin
        if (pending_counts.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
          count_i <= pending_counts.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      expected_pixels.push_back(palette_color(count_i));
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected pixel r=%0d g=%0d b=%0d", red_o, green_o, blue_o);
        end
      end else begin
        want = expected_pixels.pop_front();
        if (red_o !== want.red || green_o !== want.green || blue_o !== want.blue) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, red_o, green_o, blue_o);
          end
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_MAX_COUNT) limit_reg = data;
    else palette_reg = theme_e'(data[0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (pending_counts.size() != 0 || in_valid_i || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (30) @(negedge clk_i);
  endtask

  task automatic queue_counts(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    pending_counts.push_back(a);
    pending_counts.push_back(b);
    pending_counts.push_back(c);
  endtask

  initial begin
    logic [15:0] lim;
    logic [15:0] tsel;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_counts(16'd0, 16'd1, 16'd500);
    queue_counts(16'd999, 16'd1000, 16'hFFFF);
    drain();
    write_reg(REG_THEME, 16'd1);
    queue_counts(16'd0, 16'd33, 16'd34);
    queue_counts(16'd250, 16'd999, 16'd1000);
    drain();
    write_reg(REG_MAX_COUNT, 16'hFFFF);
    queue_counts(16'hFFFE, 16'hFFFF, 16'h5555);
    pending_counts.push_back(16'hAAAA);
    drain();
    write_reg(REG_MAX_COUNT, 16'd0);
    queue_counts(16'd0, 16'hFFFF, 16'd1234);
    drain();
    write_reg(REG_THEME, 16'hFFFE);
    write_reg(REG_MAX_COUNT, 16'd1);
    queue_counts(16'd0, 16'd1, 16'hFFFF);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0: lim = 16'hFFFF;
        1: lim = 16'd1;
        2: lim = 16'd0;
        3: lim = 16'($urandom_range(400, 2));
        default: lim = 16'($urandom_range(65535));
      endcase
      tsel = 16'($urandom_range(65535));
      tsel[0] = (p < 5) ? p[0] : !p[0];
      write_reg(REG_THEME, tsel);
      write_reg(REG_MAX_COUNT, lim);
      steady = (p == 6);
      for (int i = 0; i < 142; i++) begin
        pending_counts.push_back(pick_count(lim));
      end
      drain();
      steady = 1'b0;
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
design/icrgb_pkg.sv
design/icrgb_front.sv
design/icrgb_fifo.sv
design/icrgb_div.sv
design/icrgb_color.sv
design/iteration_count_to_rgb_palette.sv
tb/tb_iteration_count_to_rgb_palette.sv
